// File: sv/prcd_pkg.sv
package prcd_pkg;

  localparam int unsigned THR_W   = 15;
  localparam int unsigned WIN_W   = 16;
  localparam int unsigned DEPTH_W = 16;
  localparam int unsigned TIME_W  = 40;
  localparam int unsigned CFG_AW  = 4;
  localparam int unsigned CFG_DW  = 32;

  // Depth arithmetic is carried two bits wider than the input so that
  // wrist minus threshold never wraps.
  localparam int unsigned DIFF_W  = DEPTH_W + 2;
  // Time differences are signed and one bit wider than a timestamp.
  localparam int unsigned DT_W    = TIME_W + 1;

  localparam logic [THR_W-1:0] THR_RST      = THR_W'(200);
  localparam logic [WIN_W-1:0] MIN_WIN_RST  = WIN_W'(50);
  localparam logic [WIN_W-1:0] MAX_WIN_RST  = WIN_W'(400);
  localparam logic [WIN_W-1:0] COOLDOWN_RST = WIN_W'(300);

  typedef enum logic [1:0] {
    REG_THRESHOLD  = 2'd0,
    REG_MIN_WINDOW = 2'd1,
    REG_MAX_WINDOW = 2'd2,
    REG_COOLDOWN   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [THR_W-1:0] approach_threshold;
    logic [WIN_W-1:0] min_window_ms;
    logic [WIN_W-1:0] max_window_ms;
    logic [WIN_W-1:0] cooldown_ms;
  } cfg_t;

endpackage

// File: sv/push_retreat_click_detector.sv
// Each accepted item passes the input register and then the result register.
// Throughput: one item per cycle, set by the single compare stage between the
// input register and the result register; the input stalls only while the
// result register is full and not taken.
// Reset: synchronous, active low; clears both pipeline stages, the gesture state
// and restores the register defaults.
module push_retreat_click_detector (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [prcd_pkg::DEPTH_W-1:0] in_tip_depth,
  input  logic signed [prcd_pkg::DEPTH_W-1:0] in_wrist_depth,
  input  logic        [prcd_pkg::TIME_W-1:0]  in_time_ms,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_click,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [prcd_pkg::CFG_AW-1:0]         paddr,
  input  logic [prcd_pkg::CFG_DW-1:0]         pwdata,
  output logic [prcd_pkg::CFG_DW-1:0]         prdata,
  output logic                                pready
);

  prcd_pkg::cfg_t                     cfg;
  logic                               s1_vld_r;
  logic signed [prcd_pkg::DEPTH_W-1:0] s1_tip_r;
  logic signed [prcd_pkg::DEPTH_W-1:0] s1_wrist_r;
  logic        [prcd_pkg::TIME_W-1:0]  s1_time_r;
  logic                               out_valid_r;
  logic                               out_click_r;
  logic                               adv;
  logic                               s1_fire;
  logic                               click_nxt;

  assign adv       = !out_valid_r || out_ready;
  assign s1_fire   = s1_vld_r && adv;
  assign in_ready  = !s1_vld_r || adv;
  assign out_valid = out_valid_r;
  assign out_click = out_click_r;

  prcd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  prcd_engine u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (s1_fire),
    .tip_depth   (s1_tip_r),
    .wrist_depth (s1_wrist_r),
    .time_ms     (s1_time_r),
    .cfg         (cfg),
    .click       (click_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_vld_r <= in_valid;
      end
      if (adv) begin
        out_valid_r <= s1_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_tip_r   <= in_tip_depth;
      s1_wrist_r <= in_wrist_depth;
      s1_time_r  <= in_time_ms;
    end
    if (s1_fire) begin
      out_click_r <= click_nxt;
    end
  end

endmodule

// File: sv/prcd_cfg.sv
module prcd_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [prcd_pkg::CFG_AW-1:0]   paddr,
  input  logic [prcd_pkg::CFG_DW-1:0]   pwdata,
  output logic [prcd_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready,
  output prcd_pkg::cfg_t                cfg
);

  prcd_pkg::cfg_t     cfg_r;
  prcd_pkg::cfg_t     cfg_nxt;
  prcd_pkg::reg_idx_t idx;
  logic               wr_en;

  assign idx    = prcd_pkg::reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        prcd_pkg::REG_THRESHOLD:  cfg_nxt.approach_threshold = pwdata[prcd_pkg::THR_W-1:0];
        prcd_pkg::REG_MIN_WINDOW: cfg_nxt.min_window_ms      = pwdata[prcd_pkg::WIN_W-1:0];
        prcd_pkg::REG_MAX_WINDOW: cfg_nxt.max_window_ms      = pwdata[prcd_pkg::WIN_W-1:0];
        prcd_pkg::REG_COOLDOWN:   cfg_nxt.cooldown_ms        = pwdata[prcd_pkg::WIN_W-1:0];
        default:                  cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      prcd_pkg::REG_THRESHOLD:
        prdata = prcd_pkg::CFG_DW'(cfg_r.approach_threshold);
      prcd_pkg::REG_MIN_WINDOW:
        prdata = prcd_pkg::CFG_DW'(cfg_r.min_window_ms);
      prcd_pkg::REG_MAX_WINDOW:
        prdata = prcd_pkg::CFG_DW'(cfg_r.max_window_ms);
      prcd_pkg::REG_COOLDOWN:
        prdata = prcd_pkg::CFG_DW'(cfg_r.cooldown_ms);
      default:
        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.approach_threshold <= prcd_pkg::THR_RST;
      cfg_r.min_window_ms      <= prcd_pkg::MIN_WIN_RST;
      cfg_r.max_window_ms      <= prcd_pkg::MAX_WIN_RST;
      cfg_r.cooldown_ms        <= prcd_pkg::COOLDOWN_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// File: sv/prcd_engine.sv
module prcd_engine (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                step,
  input  logic signed [prcd_pkg::DEPTH_W-1:0] tip_depth,
  input  logic signed [prcd_pkg::DEPTH_W-1:0] wrist_depth,
  input  logic        [prcd_pkg::TIME_W-1:0]  time_ms,
  input  prcd_pkg::cfg_t                      cfg,
  output logic                                click
);

  logic                               approaching_r, approaching_nxt;
  logic                               click_seen_r, click_seen_nxt;
  logic [prcd_pkg::TIME_W-1:0]        phase_start_r, phase_start_nxt;
  logic [prcd_pkg::TIME_W-1:0]        last_click_r, last_click_nxt;

  logic signed [prcd_pkg::DIFF_W-1:0] tip_x;
  logic signed [prcd_pkg::DIFF_W-1:0] push_lim;
  logic signed [prcd_pkg::DIFF_W-1:0] retreat_lim;
  logic signed [prcd_pkg::DT_W-1:0]   since;
  logic signed [prcd_pkg::DT_W-1:0]   dur;
  logic signed [prcd_pkg::DT_W-1:0]   cooldown_x;
  logic signed [prcd_pkg::DT_W-1:0]   min_x;
  logic signed [prcd_pkg::DT_W-1:0]   max_x;
  logic                               in_cooldown;
  logic                               pushed;
  logic                               retreated;
  logic                               in_window;
  logic                               timed_out;

  always_comb begin
    tip_x       = prcd_pkg::DIFF_W'(tip_depth);
    push_lim    = prcd_pkg::DIFF_W'(wrist_depth)
                - $signed(prcd_pkg::DIFF_W'(cfg.approach_threshold));
    retreat_lim = prcd_pkg::DIFF_W'(wrist_depth)
                - $signed(prcd_pkg::DIFF_W'(cfg.approach_threshold[prcd_pkg::THR_W-1:1]));
    since       = $signed({1'b0, time_ms}) - $signed({1'b0, last_click_r});
    dur         = $signed({1'b0, time_ms}) - $signed({1'b0, phase_start_r});
    cooldown_x  = $signed(prcd_pkg::DT_W'(cfg.cooldown_ms));
    min_x       = $signed(prcd_pkg::DT_W'(cfg.min_window_ms));
    max_x       = $signed(prcd_pkg::DT_W'(cfg.max_window_ms));
    in_cooldown = click_seen_r && (since < cooldown_x);
    pushed      = tip_x < push_lim;
    retreated   = tip_x > retreat_lim;
    in_window   = (dur >= min_x) && (dur <= max_x);
    timed_out   = dur > max_x;
  end

  always_comb begin
    approaching_nxt = approaching_r;
    click_seen_nxt  = click_seen_r;
    phase_start_nxt = phase_start_r;
    last_click_nxt  = last_click_r;
    click           = 1'b0;
    if (step && !in_cooldown) begin
      if (!approaching_r) begin
        if (pushed) begin
          approaching_nxt = 1'b1;
          phase_start_nxt = time_ms;
        end
      end else if (retreated) begin
        approaching_nxt = 1'b0;
        if (in_window) begin
          click          = 1'b1;
          last_click_nxt = time_ms;
          click_seen_nxt = 1'b1;
        end
      end else if (timed_out) begin
        approaching_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      approaching_r <= 1'b0;
      click_seen_r  <= 1'b0;
      phase_start_r <= '0;
      last_click_r  <= '0;
    end else begin
      approaching_r <= approaching_nxt;
      click_seen_r  <= click_seen_nxt;
      phase_start_r <= phase_start_nxt;
      last_click_r  <= last_click_nxt;
    end
  end

endmodule

// File: sv/prcd_checker.sv
module prcd_checker (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_click,
  input logic psel,
  input logic penable,
  input logic pready
);

  logic last_click_r;

  // Tracks whether the most recently delivered item was a click.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_click_r <= 1'b0;
    end else if (out_valid && out_ready) begin
      last_click_r <= out_click;
    end
  end

  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_click))
    else $error("result changed while stalled");

  // The input side only stalls when a finished result is waiting.
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a pending result");

  // A click ends the approach, so the next item can never be a click.
  a_no_double_click: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && last_click_r |-> !out_click)
    else $error("two clicks on consecutive items");

  // The register port never inserts wait states.
  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable |-> pready)
    else $error("register access stalled");

endmodule

bind push_retreat_click_detector prcd_checker u_prcd_checker (.*);
